// ----- sv/ahfr_pkg.sv -----
// shared types, constants and helper functions for the ascii hex frame receiver
`default_nettype none

package ahfr_pkg;

	localparam int DEF_STORE_BYTES = 512;
	localparam int DEF_MAX_CHARS   = 1020;
	localparam int MIN_FRAME       = 13;

	localparam logic [15:0] BROADCAST_ID = 16'hFFFF;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY     = 16'hA001;
	localparam logic [31:0] HDR_SEQ      = 32'h41354236;
	localparam logic [31:0] TAIL_SEQ     = 32'h42364135;
	localparam logic [7:0]  HDR_BYTE0    = 8'hA5;
	localparam logic [7:0]  HDR_BYTE1    = 8'hB6;

	typedef enum logic [1:0] {
		ACT_FEED  = 2'd0,
		ACT_READ  = 2'd1,
		ACT_RESET = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		V_DISPATCH = 3'd0,
		V_CRC_ERR  = 3'd1,
		V_LEN_ERR  = 3'd2,
		V_SHORT    = 3'd3,
		V_NO_ADDR  = 3'd4
	} verdict_t;

	typedef enum logic {
		KIND_VERDICT = 1'b0,
		KIND_READ    = 1'b1
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HDR0,
		S_HDR1,
		S_CRC,
		S_FLD,
		S_WAIT,
		S_DONE,
		S_RDWAIT,
		S_RDOUT
	} state_t;

	// what the byte coming back from the store is used for
	typedef enum logic [2:0] {
		RT_NONE,
		RT_CRC,
		RT_RCV_HI,
		RT_RCV_LO,
		RT_ID_HI,
		RT_ID_LO,
		RT_PLEN,
		RT_READ
	} rd_tag_t;

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = c - 8'h37;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = c - 8'h57;
		end
		return v[3:0];
	endfunction

	// one byte of reflected crc-16/modbus
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'd0, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- sv/ahfr_store.sv -----
// frame byte store: one write port, one read port with registered read data
`default_nettype none

module ahfr_store import ahfr_pkg::*; #(
	parameter int STORE_BYTES = DEF_STORE_BYTES,
	localparam int AW = $clog2(STORE_BYTES)
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [7:0]    rd_data
);

	logic [7:0] mem [STORE_BYTES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/ascii_hex_frame_receiver_unit.sv -----
// ascii hex frame receiver: character decode, frame store, crc and frame checks
//
// item channel (item_valid/item_stall) carries action, char_in and read_index;
// result channel (result_valid/result_stall) carries one verdict or read result.
// cfg channel (cfg_valid/cfg_ready) writes the own address; ready is always high.
// a fed character is handled in S_IDLE; a header rewrites store bytes 0/1 in S_HDR0 and S_HDR1.
// a read request goes through S_RDWAIT to S_RDOUT, which loads its byte into the output.
// a closing tail with n decoded bytes (n >= 13) walks the store one byte per cycle
// through the single read port: n-4 crc reads and 5 field reads, then S_WAIT and
// S_DONE, which gives the verdict; short frames go straight to S_DONE.
// item_stall is high while a request is being worked on; the result sits in an output
// register, so a new request is taken while an earlier result waits on result_stall.
// a result that cannot be loaded because the output is still stalled holds the block.
// reset clears the character count, the character history and the crc register and
// empties the output; the store is not cleared and holds garbage until written.
`default_nettype none

module ascii_hex_frame_receiver_unit import ahfr_pkg::*; #(
	parameter int STORE_BYTES = DEF_STORE_BYTES,
	parameter int MAX_CHARS   = DEF_MAX_CHARS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  char_in,
	input  wire logic [8:0]  read_index,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic             kind,
	output logic      [2:0]  verdict,
	output logic      [8:0]  frame_length,
	output logic      [15:0] frame_crc,
	output logic      [7:0]  read_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	localparam int AW = $clog2(STORE_BYTES);
	localparam int CW = $clog2(MAX_CHARS + 1);
	localparam int LW = CW - 1;

	state_t        state_q, state_d;
	logic [CW-1:0] count_q;
	logic [23:0]   recent_q;
	logic [3:0]    nib_q;
	logic [15:0]   crc_q;
	logic [15:0]   dev_id_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] ptr_q;
	rd_tag_t       fld_q;
	logic [15:0]   rcv_q;
	logic [15:0]   id_q;
	logic [7:0]    plen_q;
	logic [7:0]    rbyte_q;
	rd_tag_t       tag_s1;
	logic          oob_s1;

	logic          out_valid_q;
	kind_t         kind_q;
	verdict_t      verdict_q;
	logic [8:0]    flen_q;
	logic [15:0]   ccrc_q;
	logic [7:0]    rdata_q;

	logic          accept;
	logic          out_free;
	logic [3:0]    hv;
	logic [CW-1:0] cnt_inc;
	logic [31:0]   last4;
	logic          hdr_hit;
	logic          tail_hit;
	logic [LW-1:0] tail_len;
	logic [LW-1:0] cidx;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [LW-1:0] rd_idx;
	rd_tag_t       rd_tag;
	logic          rd_oob;
	logic [7:0]    store_rdata;
	logic [7:0]    rd_byte;

	logic          load_out;
	kind_t         kind_d;
	verdict_t      verdict_d;
	logic [8:0]    flen_d;
	logic [15:0]   ccrc_d;
	logic [7:0]    rdata_d;

	ahfr_store #(
		.STORE_BYTES(STORE_BYTES)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(store_rdata)
	);

	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;
	assign out_free   = !out_valid_q || !result_stall;
	assign cfg_ready  = 1'b1;

	assign hv       = hex_value(char_in);
	assign cnt_inc  = count_q + CW'(1);
	assign last4    = {recent_q, char_in};
	assign hdr_hit  = (int'(cnt_inc) > 4) && (last4 == HDR_SEQ);
	assign tail_hit = (int'(cnt_inc) >= 4) && (last4 == TAIL_SEQ);
	assign tail_len = cnt_inc[CW-1:1];
	assign cidx     = count_q[CW-1:1];

	assign rd_byte = oob_s1 ? 8'd0 : store_rdata;

	always_comb begin
		state_d   = state_q;
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_data   = '0;
		rd_en     = 1'b0;
		rd_idx    = '0;
		rd_addr   = '0;
		rd_tag    = RT_NONE;
		rd_oob    = 1'b0;
		load_out  = 1'b0;
		kind_d    = KIND_VERDICT;
		verdict_d = V_DISPATCH;
		flen_d    = '0;
		ccrc_d    = '0;
		rdata_d   = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (action)
						ACT_FEED: begin
							// odd character completes a byte
							if (count_q[0] && int'(cidx) < STORE_BYTES) begin
								wr_en   = 1'b1;
								wr_addr = AW'(cidx);
								wr_data = {nib_q, hv};
							end
							if (hdr_hit) begin
								state_d = S_HDR0;
							end else if (tail_hit) begin
								state_d = (int'(tail_len) < MIN_FRAME) ? S_DONE : S_CRC;
							end
						end
						ACT_READ: begin
							rd_en   = 1'b1;
							rd_addr = AW'(read_index);
							rd_oob  = int'(read_index) >= STORE_BYTES;
							rd_tag  = RT_READ;
							state_d = S_RDWAIT;
						end
						default: ;
					endcase
				end
			end
			S_HDR0: begin
				wr_en   = 1'b1;
				wr_addr = AW'(0);
				wr_data = HDR_BYTE0;
				state_d = S_HDR1;
			end
			S_HDR1: begin
				wr_en   = 1'b1;
				wr_addr = AW'(1);
				wr_data = HDR_BYTE1;
				state_d = S_IDLE;
			end
			S_CRC: begin
				rd_en   = 1'b1;
				rd_idx  = ptr_q;
				rd_addr = AW'(ptr_q);
				rd_oob  = int'(ptr_q) >= STORE_BYTES;
				rd_tag  = RT_CRC;
				if (ptr_q == len_q - LW'(5)) begin
					state_d = S_FLD;
				end
			end
			S_FLD: begin
				case (fld_q)
					RT_RCV_HI: rd_idx = len_q - LW'(4);
					RT_RCV_LO: rd_idx = len_q - LW'(3);
					RT_ID_HI:  rd_idx = LW'(2);
					RT_ID_LO:  rd_idx = LW'(3);
					RT_PLEN:   rd_idx = LW'(7);
					default:   rd_idx = '0;
				endcase
				rd_en   = 1'b1;
				rd_addr = AW'(rd_idx);
				rd_oob  = int'(rd_idx) >= STORE_BYTES;
				rd_tag  = fld_q;
				if (fld_q == RT_PLEN) begin
					state_d = S_WAIT;
				end
			end
			S_WAIT: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				flen_d = 9'(len_q);
				if (int'(len_q) < MIN_FRAME) begin
					verdict_d = V_SHORT;
				end else begin
					ccrc_d = crc_q;
					if (crc_q != rcv_q) begin
						verdict_d = V_CRC_ERR;
					end else if (id_q != BROADCAST_ID && id_q != dev_id_q) begin
						verdict_d = V_NO_ADDR;
					end else if (int'(plen_q) + MIN_FRAME != int'(len_q)) begin
						verdict_d = V_LEN_ERR;
					end
				end
				if (out_free) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_RDWAIT: begin
				state_d = S_RDOUT;
			end
			S_RDOUT: begin
				kind_d  = KIND_READ;
				rdata_d = rbyte_q;
				if (out_free) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			recent_q    <= '0;
			nib_q       <= '0;
			crc_q       <= CRC_INIT;
			dev_id_q    <= '0;
			fld_q       <= RT_RCV_HI;
			tag_s1      <= RT_NONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			tag_s1  <= rd_en ? rd_tag : RT_NONE;
			if (cfg_valid && cfg_ready) begin
				dev_id_q <= cfg_data;
			end
			if (accept) begin
				case (action)
					ACT_FEED: begin
						if (!count_q[0]) begin
							nib_q <= hv;
						end
						recent_q <= last4[23:0];
						if (hdr_hit) begin
							count_q <= CW'(4);
						end else if (tail_hit) begin
							count_q <= '0;
							crc_q   <= CRC_INIT;
						end else if (int'(cnt_inc) >= MAX_CHARS) begin
							count_q <= '0;
						end else begin
							count_q <= cnt_inc;
						end
					end
					ACT_RESET: begin
						count_q <= '0;
					end
					default: ;
				endcase
			end
			if (state_q == S_CRC && state_d == S_FLD) begin
				fld_q <= RT_RCV_HI;
			end else if (state_q == S_FLD) begin
				case (fld_q)
					RT_RCV_HI: fld_q <= RT_RCV_LO;
					RT_RCV_LO: fld_q <= RT_ID_HI;
					RT_ID_HI:  fld_q <= RT_ID_LO;
					RT_ID_LO:  fld_q <= RT_PLEN;
					default:   fld_q <= RT_RCV_HI;
				endcase
			end
			if (tag_s1 == RT_CRC) begin
				crc_q <= crc_byte(crc_q, rd_byte);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		oob_s1 <= rd_oob;
		if (accept && action == ACT_FEED && tail_hit) begin
			len_q <= tail_len;
			ptr_q <= '0;
		end else if (state_q == S_CRC) begin
			ptr_q <= ptr_q + LW'(1);
		end
		case (tag_s1)
			RT_RCV_HI: rcv_q[15:8] <= rd_byte;
			RT_RCV_LO: rcv_q[7:0]  <= rd_byte;
			RT_ID_HI:  id_q[15:8]  <= rd_byte;
			RT_ID_LO:  id_q[7:0]   <= rd_byte;
			RT_PLEN:   plen_q      <= rd_byte;
			RT_READ:   rbyte_q     <= rd_byte;
			default: ;
		endcase
		if (load_out) begin
			kind_q    <= kind_d;
			verdict_q <= verdict_d;
			flen_q    <= flen_d;
			ccrc_q    <= ccrc_d;
			rdata_q   <= rdata_d;
		end
	end

	assign result_valid = out_valid_q;
	assign kind         = kind_q;
	assign verdict      = verdict_q;
	assign frame_length = flen_q;
	assign frame_crc    = ccrc_q;
	assign read_data    = rdata_q;

`ifndef SYNTHESIS
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("store written and read in the same cycle");

	a_crc_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CRC) |-> (ptr_q <= len_q - LW'(5)))
		else $error("crc walk ran past the crc field");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) < MAX_CHARS)
		else $error("character count reached the limit");

	a_short_no_crc: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind == KIND_VERDICT && verdict == V_SHORT) |-> (frame_crc == 16'd0))
		else $error("short frame verdict carries a crc");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(kind) && $stable(frame_crc)))
		else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
